### sv/mf3_pkg.sv
package mf3_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // Register field widths and reset values
    localparam int FRAME_W_BITS = 11;
    localparam int FRAME_H_BITS = 16;
    localparam logic [FRAME_W_BITS-1:0] FRAME_W_RESET = 11'd1024;
    localparam logic [FRAME_H_BITS-1:0] FRAME_H_RESET = 16'd1;

    // Neighborhood count width (largest count is 9)
    localparam int DIVISOR_BITS = 4;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } t_cfg_idx;

    // Control part of one averaging job handed from front to back
    typedef struct packed {
        logic [DIVISOR_BITS-1:0] divisor;
        logic                    last;
        logic                    frame_end;
    } t_job_ctl;

endpackage

### sv/mf3_ram.sv
module mf3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

### sv/mf3_queue.sv
module mf3_queue #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNTW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_full,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CNTW-1:0]  r_count;

    assign o_full    = (r_count == CNTW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rp];

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

    // Advance pointers and track fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("job queue pushed while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("job queue popped while empty");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("job queue fill level lost a push");
`endif

endmodule

### sv/mf3_front.sv
module mf3_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16,
    localparam int CW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int SUM_BITS  = PIXEL_BITS + 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_restart,
    input  logic [CW-1:0]                        i_last_col,
    input  logic [mf3_pkg::FRAME_H_BITS-1:0]     i_height,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_action,
    input  logic signed [PIXEL_BITS-1:0]         i_pixel_in,
    output logic                                 o_push,
    output logic signed [SUM_BITS-1:0]           o_push_sum,
    output mf3_pkg::t_job_ctl                    o_push_ctl,
    input  logic                                 i_q_full
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_PUSH_A,
        S_PUSH_B
    } t_state;

    t_state                               r_state;
    logic [CW-1:0]                        r_col;
    logic [mf3_pkg::FRAME_H_BITS-1:0]     r_row;
    logic signed [PIXEL_BITS-1:0]         r_win [3][3];
    logic signed [PIXEL_BITS-1:0]         r_px;
    logic                                 r_drain;
    logic                                 r_job_b;
    logic                                 r_top_ok;
    logic                                 r_bot_ok;
    logic                                 r_left_a;
    logic                                 r_left_b;
    logic                                 r_fe;

    logic signed [PIXEL_BITS-1:0]         above_rd;
    logic signed [PIXEL_BITS-1:0]         middle_rd;
    logic                                 in_accept;
    logic                                 last_col;
    logic                                 exec_job_a;
    logic                                 exec_job_b;
    logic                                 pushing;
    logic [2:0]                           col_mask;
    logic [2:0]                           row_mask;
    logic [1:0]                           n_cols;
    logic [1:0]                           n_rows;
    logic signed [SUM_BITS-1:0]           win_sum;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign last_col   = (r_col == i_last_col);
    assign exec_job_a = (r_row != '0) && (r_col != '0);
    assign exec_job_b = (r_row != '0) && last_col;
    assign pushing    = (r_state == S_PUSH_A) || (r_state == S_PUSH_B);

    // Line buffers: read the current column, write it back in the update cycle
    mf3_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_above (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_EXEC),
        .i_wr_addr (r_col),
        .i_wr_data (middle_rd),
        .i_rd_addr (r_col),
        .o_rd_data (above_rd)
    );

    mf3_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_middle (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_EXEC),
        .i_wr_addr (r_col),
        .i_wr_data (r_px),
        .i_rd_addr (r_col),
        .o_rd_data (middle_rd)
    );

    // Build the masked neighborhood sum and its divisor for the job being pushed
    always_comb begin
        if (r_state == S_PUSH_B) begin
            col_mask = {1'b1, r_left_b, 1'b0};
        end else begin
            col_mask = {1'b1, 1'b1, r_left_a};
        end
        row_mask = {r_bot_ok, 1'b1, r_top_ok};
        n_cols   = 2'(col_mask[0]) + 2'(col_mask[1]) + 2'(col_mask[2]);
        n_rows   = 2'(row_mask[0]) + 2'(row_mask[1]) + 2'(row_mask[2]);
        win_sum  = '0;
        for (int rr = 0; rr < 3; rr++) begin
            for (int cc = 0; cc < 3; cc++) begin
                if (row_mask[rr] && col_mask[cc]) begin
                    win_sum = win_sum + SUM_BITS'(r_win[rr][cc]);
                end
            end
        end
    end

    assign o_push               = pushing && !i_q_full;
    assign o_push_sum           = win_sum;
    assign o_push_ctl.divisor   = mf3_pkg::DIVISOR_BITS'(n_cols) *
                                  mf3_pkg::DIVISOR_BITS'(n_rows);
    assign o_push_ctl.last      = (r_state == S_PUSH_B) || !r_job_b;
    assign o_push_ctl.frame_end = r_fe && ((r_state == S_PUSH_B) || !r_job_b);

    // Accept a request, update window and line buffers, then queue its jobs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[k][j] <= '0;
                end
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_px    <= i_action ? '0 : i_pixel_in;
                        r_drain <= i_action;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    for (int k = 0; k < 3; k++) begin
                        r_win[k][0] <= r_win[k][1];
                        r_win[k][1] <= r_win[k][2];
                    end
                    r_win[0][2] <= above_rd;
                    r_win[1][2] <= middle_rd;
                    r_win[2][2] <= r_px;

                    r_job_b  <= exec_job_b;
                    r_top_ok <= (r_row > mf3_pkg::FRAME_H_BITS'(1));
                    r_bot_ok <= !r_drain;
                    r_left_a <= (r_col > CW'(1));
                    r_left_b <= (r_col != '0);
                    r_fe     <= last_col && (r_row == i_height);

                    if (last_col) begin
                        r_col <= '0;
                        r_row <= (r_row >= i_height) ? '0 : r_row + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end

                    priority if (exec_job_a) begin
                        r_state <= S_PUSH_A;
                    end else if (exec_job_b) begin
                        r_state <= S_PUSH_B;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_PUSH_A: begin
                    if (!i_q_full) begin
                        r_state <= r_job_b ? S_PUSH_B : S_IDLE;
                    end
                end
                S_PUSH_B: begin
                    if (!i_q_full) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_col <= i_last_col))
        else $error("column position ran past the end of the row");
`endif

endmodule

### sv/mf3_back.sv
module mf3_back #(
    parameter int PIXEL_BITS = 16,
    localparam int SUM_BITS  = PIXEL_BITS + 4,
    localparam int MAG_BITS  = PIXEL_BITS + 3,
    localparam int SHIFT     = MAG_BITS + 4,
    localparam int RW        = SHIFT + 1,
    localparam int LO_W      = RW / 2,
    localparam int HI_W      = RW - LO_W,
    localparam int PROD_W    = MAG_BITS + HI_W,
    localparam int ACC_W     = MAG_BITS + RW
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    output logic                          o_pop,
    input  logic signed [SUM_BITS-1:0]    i_sum,
    input  mf3_pkg::t_job_ctl             i_ctl,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [PIXEL_BITS-1:0]  o_pixel_out,
    output logic                          o_last_in_run,
    output logic                          o_frame_end
);

    // Reciprocals ceil(2^SHIFT / d); exact for every magnitude below 2^MAG_BITS
    localparam logic [63:0]   ONE_SHIFT = 64'd1 << SHIFT;
    localparam logic [RW-1:0] RECIP_1   = RW'(ONE_SHIFT);
    localparam logic [RW-1:0] RECIP_2   = RW'((ONE_SHIFT + 64'd1) / 64'd2);
    localparam logic [RW-1:0] RECIP_3   = RW'((ONE_SHIFT + 64'd2) / 64'd3);
    localparam logic [RW-1:0] RECIP_4   = RW'((ONE_SHIFT + 64'd3) / 64'd4);
    localparam logic [RW-1:0] RECIP_6   = RW'((ONE_SHIFT + 64'd5) / 64'd6);
    localparam logic [RW-1:0] RECIP_9   = RW'((ONE_SHIFT + 64'd8) / 64'd9);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_DONE
    } t_state;

    t_state                               r_state;
    logic [MAG_BITS-1:0]                  r_mag;
    logic                                 r_neg;
    logic [RW-1:0]                        r_recip;
    logic [ACC_W-1:0]                     r_acc;
    logic                                 r_last;
    logic                                 r_fe;

    logic [SUM_BITS-1:0]                  sum_mag;
    logic [RW-1:0]                        recip_sel;
    logic [HI_W-1:0]                      recip_half;
    logic [PROD_W-1:0]                    prod;
    logic [PIXEL_BITS-1:0]                quot;
    logic                                 out_free;

    assign o_pop    = (r_state == S_IDLE) && !i_q_empty;
    assign out_free = !o_out_valid || i_out_ready;
    assign sum_mag  = i_sum[SUM_BITS-1] ? SUM_BITS'(-i_sum) : SUM_BITS'(i_sum);

    // Pick the reciprocal of the neighborhood count
    always_comb begin
        unique case (i_ctl.divisor)
            4'd2:    recip_sel = RECIP_2;
            4'd3:    recip_sel = RECIP_3;
            4'd4:    recip_sel = RECIP_4;
            4'd6:    recip_sel = RECIP_6;
            4'd9:    recip_sel = RECIP_9;
            default: recip_sel = RECIP_1;
        endcase
    end

    // Multiply the magnitude by one half of the reciprocal per cycle
    assign recip_half = (r_state == S_MUL_HI) ? r_recip[RW-1:LO_W] :
                                                HI_W'(r_recip[LO_W-1:0]);
    assign prod       = PROD_W'(r_mag) * PROD_W'(recip_half);
    assign quot       = r_acc[SHIFT +: PIXEL_BITS];

    // Pop a job, form the quotient in two multiply steps, then hand it to the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            o_out_valid <= (r_state == S_DONE) || (o_out_valid && !i_out_ready);
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_neg   <= i_sum[SUM_BITS-1];
                        r_mag   <= sum_mag[MAG_BITS-1:0];
                        r_recip <= recip_sel;
                        r_last  <= i_ctl.last;
                        r_fe    <= i_ctl.frame_end;
                        r_state <= S_MUL_LO;
                    end
                end
                S_MUL_LO: begin
                    r_acc   <= ACC_W'(prod);
                    r_state <= S_MUL_HI;
                end
                S_MUL_HI: begin
                    r_acc   <= r_acc + (ACC_W'(prod) << LO_W);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        o_pixel_out   <= r_neg ? -quot : quot;
                        o_last_in_run <= r_last;
                        o_frame_end   <= r_fe;
                        r_state       <= S_IDLE;
                    end
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_pixel_out) &&
                                           $stable(o_last_in_run) && $stable(o_frame_end)))
        else $error("result changed while waiting for ready");

    a_divisor_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (i_ctl.divisor == 4'd1 || i_ctl.divisor == 4'd2 || i_ctl.divisor == 4'd3 ||
                   i_ctl.divisor == 4'd4 || i_ctl.divisor == 4'd6 || i_ctl.divisor == 4'd9))
        else $error("neighborhood count outside the legal set");
`endif

endmodule

### sv/mean_filter_3x3_edge_aware.sv
// 3x3 mean filter over a raster stream of signed pixels. Each result is the mean of a pixel
// and its neighbors inside the frame (9, 6, 4, or 3/2/1 for one-wide or one-high frames),
// truncated toward zero, and results lag the input by one row; after the last row,
// frame_width drain requests (action = 1) push out the final row. A write to the frame width
// or height register restarts the frame. The front end takes each request through an update
// state and then a push state per job it queues (0, 1 or 2 jobs per request), holding while
// the job queue is full. The back end divides each neighborhood sum by a reciprocal
// multiplication split into a low-half and a high-half step, and pops its next job only
// after the previous result has entered the output register, which holds it until ready.
// The back end sets the sustained request rate. A 4-entry job queue lets the two halves
// stall independently. The line buffers need no clearing pass after reset.
module mean_filter_3x3_edge_aware #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [mf3_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [mf3_pkg::CFG_DATA_BITS-1:0]    i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_action,
    input  logic signed [PIXEL_BITS-1:0]         i_pixel_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [PIXEL_BITS-1:0]         o_pixel_out,
    output logic                                 o_last_in_run,
    output logic                                 o_frame_end
);

    localparam int CW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SUM_BITS = PIXEL_BITS + 4;
    localparam int QW       = SUM_BITS + $bits(mf3_pkg::t_job_ctl);
    localparam int Q_DEPTH  = 4;

    logic [mf3_pkg::FRAME_W_BITS-1:0]  r_frame_width;
    logic [mf3_pkg::FRAME_H_BITS-1:0]  r_frame_height;

    logic                              cfg_restart;
    logic [CW-1:0]                     last_col;
    logic [mf3_pkg::FRAME_H_BITS-1:0]  height_eff;

    logic                              push;
    logic signed [SUM_BITS-1:0]        push_sum;
    mf3_pkg::t_job_ctl                 push_ctl;
    logic                              pop;
    logic [QW-1:0]                     q_rd;
    logic                              q_full;
    logic                              q_empty;
    logic signed [SUM_BITS-1:0]        job_sum;
    mf3_pkg::t_job_ctl                 job_ctl;

    assign cfg_restart = i_cfg_wr_en &&
                         (i_cfg_index == mf3_pkg::CFG_FRAME_WIDTH ||
                          i_cfg_index == mf3_pkg::CFG_FRAME_HEIGHT);

    // Hold the frame size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= mf3_pkg::FRAME_W_RESET;
            r_frame_height <= mf3_pkg::FRAME_H_RESET;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == mf3_pkg::CFG_FRAME_WIDTH) begin
                r_frame_width <= i_cfg_wdata[mf3_pkg::FRAME_W_BITS-1:0];
            end
            if (i_cfg_index == mf3_pkg::CFG_FRAME_HEIGHT) begin
                r_frame_height <= i_cfg_wdata[mf3_pkg::FRAME_H_BITS-1:0];
            end
        end
    end

    // Clamp width to 1..MAX_WIDTH and height to at least 1
    always_comb begin
        priority if (r_frame_width == '0) begin
            last_col = '0;
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            last_col = CW'(MAX_WIDTH - 1);
        end else begin
            last_col = CW'(r_frame_width - 1'b1);
        end
        height_eff = (r_frame_height == '0) ? mf3_pkg::FRAME_H_BITS'(1) : r_frame_height;
    end

    mf3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_restart  (cfg_restart),
        .i_last_col (last_col),
        .i_height   (height_eff),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_action   (i_action),
        .i_pixel_in (i_pixel_in),
        .o_push     (push),
        .o_push_sum (push_sum),
        .o_push_ctl (push_ctl),
        .i_q_full   (q_full)
    );

    mf3_queue #(
        .WIDTH (QW),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data ({push_ctl, push_sum}),
        .i_pop     (pop),
        .o_rd_data (q_rd),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    assign job_sum = q_rd[SUM_BITS-1:0];
    assign job_ctl = mf3_pkg::t_job_ctl'(q_rd[QW-1:SUM_BITS]);

    mf3_back #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .o_pop         (pop),
        .i_sum         (job_sum),
        .i_ctl         (job_ctl),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_out   (o_pixel_out),
        .o_last_in_run (o_last_in_run),
        .o_frame_end   (o_frame_end)
    );

endmodule
